/* sv/adam_pkg.sv */
// shared types, constants and opcodes for the adam optimizer update block
package adam_pkg;

  localparam int unsigned ParamCount = 1024;
  localparam int unsigned IdxW = 10;
  localparam int unsigned AddrW = $clog2(ParamCount);

  localparam logic [31:0] LrReset  = 32'd4294967;
  localparam logic [31:0] B1Reset  = 32'd3865470566;
  localparam logic [31:0] B2Reset  = 32'd4290672329;
  localparam logic [31:0] EpsReset = 32'd43;

  localparam logic [1:0] RegLr  = 2'd0;
  localparam logic [1:0] RegB1  = 2'd1;
  localparam logic [1:0] RegB2  = 2'd2;
  localparam logic [1:0] RegEps = 2'd3;

  typedef struct packed {
    logic [IdxW-1:0]    param_index;
    logic signed [31:0] weight_in;
    logic signed [31:0] gradient;
    logic [15:0]        step;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]    index_out;
    logic signed [31:0] weight_out;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic [31:0] lr;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] eps;
  } cfg_t;

  // 32x32 multiplier request; one marks b as exactly 2^32
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        one;
  } mul_req_t;

endpackage

/* sv/adam_mul.sv */
// registered 32x32 unsigned multiplier shared by the sequencer
module adam_mul (
  input  logic              clk,
  input  adam_pkg::mul_req_t req,
  output logic [63:0]       prod
);

  always_ff @(posedge clk) begin
    if (req.one) begin
      prod <= {req.a, 32'd0};
    end else begin
      prod <= 64'(req.a) * 64'(req.b);
    end
  end

endmodule

/* sv/adam_regs.sv */
// apb configuration registers
module adam_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output adam_pkg::cfg_t  cfg
);

  logic [1:0] sel;
  logic       hit;

  assign sel = paddr[3:2];
  assign hit = (paddr[1:0] == 2'd0);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lr  <= adam_pkg::LrReset;
      cfg.b1  <= adam_pkg::B1Reset;
      cfg.b2  <= adam_pkg::B2Reset;
      cfg.eps <= adam_pkg::EpsReset;
    end else if (psel && penable && pwrite && hit) begin
      case (sel)
        adam_pkg::RegLr:  cfg.lr  <= pwdata;
        adam_pkg::RegB1:  cfg.b1  <= pwdata;
        adam_pkg::RegB2:  cfg.b2  <= pwdata;
        adam_pkg::RegEps: cfg.eps <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (hit) begin
      case (sel)
        adam_pkg::RegLr:  prdata = cfg.lr;
        adam_pkg::RegB1:  prdata = cfg.b1;
        adam_pkg::RegB2:  prdata = cfg.b2;
        adam_pkg::RegEps: prdata = cfg.eps;
        default: prdata = 32'd0;
      endcase
    end
  end

endmodule

/* sv/adam_optimizer_update.sv */
// adam optimizer update engine: moment store, sequencer and shared multiplier
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid / in_ready   | adam_pkg::in_word_t
//   out     | output    | out_valid / out_ready | adam_pkg::out_word_t
//   apb     | input     | psel/penable/pready   | 32-bit registers at 4*i
//
// one word is handled at a time: the sequencer steps the single 32x32
// multiplier through the two powers, plus bit-serial square roots (32 and
// 48 steps) and bit-serial divisions (104 and 34 steps, the second skipped
// on a zero or capped update); the next word is taken only once this one
// has moved to the result register
// after reset a clearing pass zeroes all 1024 entries of the moment store; no word
// is taken meanwhile
// in_ready is high only in idle with the result register empty or draining
module adam_optimizer_update (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  adam_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output adam_pkg::out_word_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_M1    = 5'd3;
  localparam logic [4:0] S_M2    = 5'd4;
  localparam logic [4:0] S_V     = 5'd5;
  localparam logic [4:0] S_POW   = 5'd6;
  localparam logic [4:0] S_PWAIT = 5'd7;
  localparam logic [4:0] S_SQV   = 5'd8;
  localparam logic [4:0] S_SQD   = 5'd9;
  localparam logic [4:0] S_DIV1  = 5'd10;
  localparam logic [4:0] S_DEN   = 5'd11;
  localparam logic [4:0] S_DIV2  = 5'd12;
  localparam logic [4:0] S_FIN   = 5'd13;
  localparam logic [4:0] S_MULW  = 5'd14;

  adam_pkg::cfg_t cfg;

  adam_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  adam_pkg::mul_req_t mreq;
  logic [63:0] mprod;

  adam_mul u_mul (.clk(clk), .req(mreq), .prod(mprod));

  // moment store
  logic [31:0] mem_m [adam_pkg::ParamCount];
  logic [63:0] mem_v [adam_pkg::ParamCount];
  logic [adam_pkg::AddrW-1:0] waddr, raddr;
  logic        we;
  logic [31:0] wm;
  logic [63:0] wv;
  logic [31:0] rm;
  logic [63:0] rv;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_m[waddr] <= wm;
      mem_v[waddr] <= wv;
    end
    rm <= mem_m[raddr];
    rv <= mem_v[raddr];
  end

  logic [4:0]  state;
  logic [5:0]  ph;        // micro step inside a state
  logic [6:0]  cnt;
  logic [adam_pkg::AddrW:0] clr;
  adam_pkg::in_word_t item;
  logic [15:0] expo;
  logic        pw2;       // 0: beta1 power, 1: beta2 power
  logic [63:0] base, acc;
  logic [63:0] dm, dv;
  logic signed [65:0] macc;
  logic [63:0] t0, t1, t2, t3;
  logic signed [31:0] mnew;
  logic [63:0] vnew;
  logic [63:0] sq, sdv;
  // shared restoring root / divider registers
  logic [127:0] rx, rres, rbit;
  logic [127:0] num, den;
  logic [33:0]  u;
  logic [63:0] q1, dend;
  logic [63:0] mag;
  logic [63:0] aval;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    raddr = item.param_index[adam_pkg::AddrW-1:0];
    we = 1'b0;
    waddr = item.param_index[adam_pkg::AddrW-1:0];
    wm = mnew;
    wv = vnew;
    if (state == S_CLR) begin
      we = 1'b1;
      waddr = clr[adam_pkg::AddrW-1:0];
      wm = 32'd0;
      wv = 64'd0;
    end else if (state == S_V && ph == 6'd5) begin
      we = 1'b1;
    end
  end

  logic [63:0] gabs;
  logic        gneg, mneg_old;
  logic [63:0] mabs_old;
  assign gneg = item.gradient[31];
  assign gabs = gneg ? 64'(-{{32{item.gradient[31]}}, item.gradient})
                     : 64'({32'd0, item.gradient});
  assign mneg_old = rm[31];
  assign mabs_old = mneg_old ? 64'(-{{32{rm[31]}}, rm}) : {32'd0, rm};

  // multiplier operand select
  always_comb begin
    mreq.a = 32'd0;
    mreq.b = 32'd0;
    mreq.one = 1'b0;
    case (state)
      S_M1: begin
        if (ph == 6'd0) begin
          mreq.a = mabs_old[31:0]; mreq.b = cfg.b1;
        end else begin
          mreq.a = gabs[31:0]; mreq.b = 32'(33'h1_0000_0000 - 33'(cfg.b1));
          mreq.one = (cfg.b1 == 32'd0);
        end
      end
      S_M2: begin
        mreq.a = gabs[31:0]; mreq.b = gabs[31:0];
      end
      S_V: begin
        case (ph)
          6'd0: begin mreq.a = rv[31:0];  mreq.b = cfg.b2; end
          6'd1: begin mreq.a = rv[63:32]; mreq.b = cfg.b2; end
          6'd2: begin
            mreq.a = t0[31:0];  mreq.b = 32'(33'h1_0000_0000 - 33'(cfg.b2));
            mreq.one = (cfg.b2 == 32'd0);
          end
          default: begin
            mreq.a = t0[63:32]; mreq.b = 32'(33'h1_0000_0000 - 33'(cfg.b2));
            mreq.one = (cfg.b2 == 32'd0);
          end
        endcase
      end
      S_POW: begin
        if (ph[0] == 1'b0) begin
          mreq.a = acc[31:0]; mreq.b = base[31:0];
        end else begin
          mreq.a = base[31:0]; mreq.b = base[31:0];
        end
      end
      S_MULW: begin
        case (ph)
          6'd0: begin mreq.a = dm[31:0];  mreq.b = dend[31:0]; end
          6'd1: begin mreq.a = dm[31:0];  mreq.b = dend[63:32]; end
          6'd2: begin mreq.a = {31'd0, dm[32]}; mreq.b = dend[31:0]; end
          6'd3: begin mreq.a = {31'd0, dm[32]}; mreq.b = dend[63:32]; end
          default: begin mreq.a = mag[31:0]; mreq.b = cfg.lr; end
        endcase
      end
      default: ;
    endcase
  end

  // full-precision helpers for power operand when value is exactly one (2^32)
  logic [63:0] pw_prod_acc, pw_prod_base;
  assign pw_prod_acc  = acc[32]  ? base : (mprod + 64'h8000_0000) >> 32;
  assign pw_prod_base = base[32] ? base : (mprod + 64'h8000_0000) >> 32;

  logic signed [65:0] msum;
  logic [65:0] mmag;
  logic [63:0] mr;
  assign msum = macc;
  assign mmag = msum[65] ? 66'(-msum) : 66'(msum);
  assign mr = 64'((mmag + 66'h8000_0000) >> 32);

  logic [127:0] rtry;
  assign rtry = rres + rbit;

  logic signed [35:0] nw;
  logic signed [35:0] wext;
  logic signed [35:0] uext;
  assign wext = 36'(item.weight_in);
  assign uext = $signed({2'b00, u});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr <= '0;
      out_valid <= 1'b0;
      ph <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (clr == (adam_pkg::AddrW+1)'(adam_pkg::ParamCount - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            state <= S_RD;
            ph <= '0;
          end
        end
        S_RD: begin
          ph <= ph + 1'b1;
          if (ph == 6'd1) begin
            state <= S_M1; ph <= '0;
          end
        end
        S_M1: begin
          // issue b1*|m| then (1-b1)*|g|, collect signed sum
          ph <= ph + 1'b1;
          if (ph == 6'd1) macc <= mneg_old ? -66'(mprod) : 66'(mprod);
          if (ph == 6'd2) begin
            macc <= macc + (gneg ? -66'(mprod) : 66'(mprod));
            ph <= '0;
            state <= S_M2;
          end
        end
        S_M2: begin
          ph <= ph + 1'b1;
          if (ph == 6'd0) mnew <= msum[65] ? -32'(mr) : 32'(mr);
          if (ph == 6'd1) begin
            t0 <= mprod;
            ph <= '0;
            state <= S_V;
          end
        end
        S_V: begin
          // products land in the cycle after issue; t1..t3 collect them
          ph <= ph + 1'b1;
          case (ph)
            6'd1: t1 <= mprod;
            6'd2: t2 <= mprod;
            6'd3: t3 <= mprod;
            6'd4: begin
              vnew <= t2 + (t1 >> 32) + mprod + (t3 >> 32)
                    + ((64'(t1[31:0]) + 64'(t3[31:0]) + 64'h8000_0000) >> 32);
              ph <= ph + 1'b1;
            end
            default: ;
          endcase
          if (ph == 6'd5) begin
            ph <= '0; state <= S_POW;
            expo <= (item.step == 16'd0) ? 16'd1 : item.step;
            base <= {32'd0, cfg.b1}; acc <= 64'h1_0000_0000; pw2 <= 1'b0;
          end
        end
        S_POW: begin
          ph <= ph + 1'b1;
          if (ph == 6'd1) begin
            if (expo[0]) acc <= pw_prod_acc;
          end
          if (ph == 6'd2) begin
            base <= pw_prod_base;
            expo <= expo >> 1;
            ph <= '0;
            if (expo == 16'd1) state <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (!pw2) begin
            dm <= 64'h1_0000_0000 - acc;
            pw2 <= 1'b1;
            expo <= (item.step == 16'd0) ? 16'd1 : item.step;
            base <= {32'd0, cfg.b2}; acc <= 64'h1_0000_0000;
            state <= S_POW;
          end else begin
            dv <= 64'h1_0000_0000 - acc;
            rx <= {64'd0, vnew}; rres <= '0; rbit <= 128'd1 << 62; cnt <= '0;
            state <= S_SQV;
          end
        end
        S_SQV: begin
          if (rx >= rtry) begin
            rx <= rx - rtry; rres <= (rres >> 1) + rbit;
          end else rres <= rres >> 1;
          rbit <= rbit >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == 7'd31) begin
            state <= S_SQD; cnt <= '0;
          end
        end
        S_SQD: begin
          if (cnt == 7'd0) begin
            sq <= rres[63:0];
            rx <= {32'd0, dv, 32'd0}; rres <= '0; rbit <= 128'd1 << 94;
            cnt <= 7'd1;
          end else begin
            if (rx >= rtry) begin
              rx <= rx - rtry; rres <= (rres >> 1) + rbit;
            end else rres <= rres >> 1;
            rbit <= rbit >> 2;
            cnt <= cnt + 1'b1;
            if (cnt == 7'd48) begin
              state <= S_DIV1; cnt <= '0;
            end
          end
        end
        S_DIV1: begin
          // q = floor(sq * 2^40 / sdv), restoring long division
          if (cnt == 7'd0) begin
            sdv <= (dv == 64'h1_0000_0000) ? 64'h1_0000_0000 : rres[63:0];
            num <= {24'd0, sq, 40'd0};
            q1 <= '0;
            cnt <= 7'd1;
          end else begin
            if (num >= ({64'd0, sdv} << (7'd104 - cnt))) begin
              num <= num - ({64'd0, sdv} << (7'd104 - cnt));
              q1 <= q1 | (64'd1 << (7'd104 - cnt));
            end
            cnt <= cnt + 1'b1;
            if (cnt == 7'd104) begin
              state <= S_DEN; cnt <= '0;
            end
          end
        end
        S_DEN: begin
          dend <= q1 + {32'd0, cfg.eps};
          mag <= mnew[31] ? 64'(-{{32{mnew[31]}}, mnew}) : {32'd0, mnew};
          state <= S_MULW; ph <= '0;
        end
        S_MULW: begin
          ph <= ph + 1'b1;
          case (ph)
            6'd1: den <= {64'd0, mprod};
            6'd2: den <= den + {32'd0, mprod, 32'd0};
            6'd3: den <= den + {32'd0, mprod, 32'd0};
            6'd4: den <= den + {mprod, 64'd0};
            6'd5: begin
              aval <= mprod;
              num <= {mprod, 64'd0} >> 32;
              u <= '0; cnt <= '0;
              state <= S_DIV2;
            end
            default: ;
          endcase
        end
        S_DIV2: begin
          if (aval == 64'd0) begin
            u <= '0; state <= S_FIN;
          end else if (cnt == 7'd0) begin
            if (num >= (den << 33)) begin
              u <= 34'h2_0000_0000; state <= S_FIN;
            end else cnt <= 7'd1;
          end else begin
            if (num >= (den << (7'd34 - cnt))) begin
              num <= num - (den << (7'd34 - cnt));
              u <= u | (34'd1 << (7'd34 - cnt));
            end
            cnt <= cnt + 1'b1;
            if (cnt == 7'd34) state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data.index_out <= item.param_index;
            if (nw > 36'sh0_7FFF_FFFF) begin
              out_data.weight_out <= 32'sh7FFF_FFFF; out_data.saturated <= 1'b1;
            end else if (nw < -36'sh0_8000_0000) begin
              out_data.weight_out <= 32'sh8000_0000; out_data.saturated <= 1'b1;
            end else begin
              out_data.weight_out <= nw[31:0]; out_data.saturated <= 1'b0;
            end
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign nw = mnew[31] ? wext + uext : wext - uext;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_clr_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !out_valid) else $error("result during clear");
`endif

endmodule

/* tb/tb_adam_optimizer_update.sv */
// self-checking testbench for the adam optimizer update engine
module tb_adam_optimizer_update;

  localparam int unsigned CycleLimit = 6000000;
  localparam logic [63:0] One32 = 64'h1_0000_0000;
  localparam logic [63:0] Half32 = 64'h8000_0000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  adam_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  adam_pkg::out_word_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  adam_optimizer_update u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [31:0] lr_q, b1_q, b2_q, eps_q;
  logic signed [31:0] m_store [adam_pkg::ParamCount];
  logic [63:0] v_store [adam_pkg::ParamCount];
  logic [15:0] last_step [adam_pkg::ParamCount];

  adam_pkg::in_word_t word_q[$];
  adam_pkg::out_word_t update_q[$];
  int unsigned cycles, n_in, n_out, n_sat, n_err;
  int unsigned in_gap, out_gap;
  bit in_took, quiet;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + Half32) >> 32;
  endfunction

  function automatic logic [63:0] frac_pow(logic [63:0] base, logic [15:0] e);
    logic [63:0] acc;
    acc = One32;
    while (e != 0) begin
      if (e[0]) acc = frac_mul(acc, base);
      base = frac_mul(base, base);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic adam_pkg::out_word_t adam_update(adam_pkg::in_word_t w);
    adam_pkg::out_word_t r;
    logic [9:0] idx;
    logic [15:0] stp;
    logic signed [95:0] macc;
    logic [95:0] mmag;
    logic signed [63:0] m, nw;
    logic [63:0] g2, lo, w1, f1, w2, f2, v, dm, dv, sdv, sq, q1, rem, den_d, mag, a, u;
    logic [127:0] num, den, t;
    idx = 10'(w.param_index % adam_pkg::ParamCount);
    stp = (w.step == 0) ? 16'd1 : w.step;
    macc = $signed({64'd0, b1_q}) * m_store[idx]
         + $signed({32'd0, One32 - b1_q}) * w.gradient;
    mmag = macc < 0 ? -macc : macc;
    mmag = (mmag + Half32) >> 32;
    m = macc < 0 ? -$signed(mmag[63:0]) : $signed(mmag[63:0]);
    m_store[idx] = m[31:0];
    g2 = 64'(w.gradient) * 64'(w.gradient);
    lo = (v_store[idx] & 64'hFFFF_FFFF) * b2_q;
    w1 = (v_store[idx] >> 32) * b2_q + (lo >> 32);
    f1 = lo & 64'hFFFF_FFFF;
    lo = (g2 & 64'hFFFF_FFFF) * (One32 - b2_q);
    w2 = (g2 >> 32) * (One32 - b2_q) + (lo >> 32);
    f2 = lo & 64'hFFFF_FFFF;
    v = w1 + w2 + ((f1 + f2 + Half32) >> 32);
    v_store[idx] = v;
    dm = One32 - frac_pow({32'd0, b1_q}, stp);
    dv = One32 - frac_pow({32'd0, b2_q}, stp);
    sdv = (dv == One32) ? One32 : isqrt(dv << 32);
    sq = isqrt(v);
    q1 = (sq << 32) / sdv;
    rem = (sq << 32) % sdv;
    den_d = (q1 << 8) + ((rem << 8) / sdv) + eps_q;
    mag = m < 0 ? -m : m;
    a = mag * lr_q;
    u = 0;
    if (a != 0) begin
      num = {32'd0, a, 32'd0};
      den = 128'(dm) * 128'(den_d);
      if (num >= (den << 33)) begin
        u = 64'h1 << 33;
      end else begin
        for (int i = 32; i >= 0; i--) begin
          t = den << i;
          if (num >= t) begin
            num = num - t;
            u[i] = 1'b1;
          end
        end
      end
    end
    nw = m < 0 ? 64'(w.weight_in) + $signed(u) : 64'(w.weight_in) - $signed(u);
    r.saturated = 1'b0;
    if (nw > 64'sh7FFF_FFFF) begin
      nw = 64'sh7FFF_FFFF;
      r.saturated = 1'b1;
    end else if (nw < -64'sh8000_0000) begin
      nw = -64'sh8000_0000;
      r.saturated = 1'b1;
    end
    r.index_out = w.param_index;
    r.weight_out = nw[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    adam_pkg::out_word_t e;
    cycles <= cycles + 1;
    in_took = !rst && in_valid && in_ready;
    if (in_took) begin
      update_q.push_back(adam_update(in_data));
      n_in <= n_in + 1;
    end
    if (!rst && out_valid && out_ready) begin
      n_out <= n_out + 1;
      if (update_q.size() == 0) begin
        $error("unexpected word index_out %0d", out_data.index_out);
        n_err = n_err + 1;
      end else begin
        e = update_q.pop_front();
        if (out_data.saturated) n_sat <= n_sat + 1;
        if (out_data.index_out !== e.index_out) begin
          $error("index_out expected %0d actual %0d", e.index_out, out_data.index_out);
          n_err = n_err + 1;
        end
        if (out_data.weight_out !== e.weight_out) begin
          $error("weight_out expected %h actual %h", e.weight_out, out_data.weight_out);
          n_err = n_err + 1;
        end
        if (out_data.saturated !== e.saturated) begin
          $error("saturated expected %0d actual %0d", e.saturated, out_data.saturated);
          n_err = n_err + 1;
        end
      end
    end
    if (cycles >= CycleLimit) begin
      $display("FAIL adam_optimizer_update");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        in_data <= word_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stalls
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic apb_write(logic [1:0] regi, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regi, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (regi)
      adam_pkg::RegLr: lr_q = val;
      adam_pkg::RegB1: b1_q = val;
      adam_pkg::RegB2: b2_q = val;
      adam_pkg::RegEps: eps_q = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2, logic [31:0] eps);
    apb_write(adam_pkg::RegLr, lr);
    apb_write(adam_pkg::RegB1, b1);
    apb_write(adam_pkg::RegB2, b2);
    apb_write(adam_pkg::RegEps, eps);
  endtask

  task automatic drain();
    @(posedge clk);
    while (word_q.size() != 0 || in_valid || update_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_word(logic [9:0] idx, logic [31:0] w, logic [31:0] g, logic [15:0] s);
    adam_pkg::in_word_t x;
    x.param_index = idx;
    x.weight_in = w;
    x.gradient = g;
    x.step = s;
    word_q.push_back(x);
  endtask

  task automatic push_random(int unsigned count);
    logic [9:0] idx;
    logic [15:0] s;
    logic [31:0] w, g;
    for (int unsigned k = 0; k < count; k++) begin
      idx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
      if ($urandom_range(0, 4) != 0) begin
        last_step[idx] = last_step[idx] + 1;
        s = last_step[idx];
      end else begin
        s = 16'($urandom);
      end
      case ($urandom_range(0, 3))
        0: g = $urandom;
        1: g = $signed(32'($urandom_range(0, 33554432))) - 32'sd16777216;
        2: g = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: g = $signed(32'($urandom_range(0, 1024))) - 32'sd512;
      endcase
      w = ($urandom_range(0, 2) == 0) ? $urandom
                                      : $signed(32'($urandom_range(0, 67108864))) - 32'sd33554432;
      push_word(idx, w, g, s);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cycles = 0;
    n_in = 0;
    n_out = 0;
    n_sat = 0;
    n_err = 0;
    in_gap = 0;
    out_gap = 0;
    in_took = 1'b0;
    quiet = 1'b0;
    lr_q = adam_pkg::LrReset;
    b1_q = adam_pkg::B1Reset;
    b2_q = adam_pkg::B2Reset;
    eps_q = adam_pkg::EpsReset;
    for (int i = 0; i < adam_pkg::ParamCount; i++) begin
      m_store[i] = '0;
      v_store[i] = '0;
      last_step[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes at reset settings
    push_word(10'd0, 32'h0000_0000, 32'h0000_0000, 16'd1);
    push_word(10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
    push_word(10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 16'd65535);
    push_word(10'd1, 32'h8000_0000, 32'h8000_0000, 16'd1);
    push_word(10'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd2);
    push_word(10'd3, 32'h0100_0000, 32'hFF00_0000, 16'd1);
    push_word(10'd3, 32'hFFFF_FFFF, 32'h0000_0001, 16'd2);
    push_word(10'd682, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);
    push_word(10'd341, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555);
    drain();

    // zero denominator and huge update
    set_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
    push_word(10'd20, 32'h0000_0000, 32'h0000_0001, 16'd1);
    push_word(10'd21, 32'h0000_0000, 32'hFFFF_FFFF, 16'd1);
    push_word(10'd22, 32'h7000_0000, 32'h7FFF_FFFF, 16'd3);
    drain();
    // zero rate
    set_all(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    push_word(10'd23, 32'h1234_5678, 32'h7FFF_FFFF, 16'd1);
    push_word(10'd23, 32'h8000_0000, 32'h8000_0000, 16'd65535);
    drain();

    // random phases across register settings
    set_all(adam_pkg::LrReset, adam_pkg::B1Reset, adam_pkg::B2Reset, adam_pkg::EpsReset);
    push_random(400);
    drain();
    set_all(32'd0, 32'd0, 32'd0, 32'd0);
    push_random(150);
    drain();
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_random(150);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_all($urandom >> $urandom_range(0, 24), $urandom, $urandom, $urandom >> $urandom_range(0, 31));
      push_random(200);
      drain();
    end
    set_all(adam_pkg::LrReset, adam_pkg::B1Reset, adam_pkg::B2Reset, adam_pkg::EpsReset);
    quiet = 1'b1;
    push_random(200);
    drain();
    repeat (700) @(posedge clk);

    $display("covered %0d words, %0d results, %0d clipped, across 10 register settings",
             n_in, n_out, n_sat);
    if (n_err == 0 && update_q.size() == 0) begin
      $display("PASS adam_optimizer_update");
    end else begin
      $display("FAIL adam_optimizer_update");
    end
    $finish;
  end

endmodule
